// File: sv/fspa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fspa_pkg;

    localparam int STRIDE_W = 21;
    localparam int CHUNK_W  = 9;
    localparam int SLOT_W   = 8;
    localparam int OFFS_W   = 28;
    localparam int CNT_W    = 9;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [15:0] STRIDE_RESET = 16'd256;
    localparam logic [15:0] CHUNK_RESET  = 16'd256;

    typedef enum logic {
        REG_STRIDE = 1'b0,
        REG_CHUNK  = 1'b1
    } reg_idx_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_GRANT = 2'd0,
        ST_FULL  = 2'd1,
        ST_FREE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } fsm_t;

    typedef struct packed {
        logic [STRIDE_W-1:0] slot_stride;
        logic [CHUNK_W-1:0]  slots_in_chunk;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/fspa_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fspa_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output fspa_pkg::cfg_t     cfg
);
    import fspa_pkg::*;

    logic [STRIDE_W-1:0] stride_reg;
    logic [CHUNK_W-1:0]  chunk_reg;
    reg_idx_t            sel;
    logic                wr_en;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= STRIDE_W'(STRIDE_RESET);
            chunk_reg  <= CHUNK_W'(CHUNK_RESET);
        end else if (wr_en) begin
            case (sel)
                REG_STRIDE: stride_reg <= pwdata[STRIDE_W-1:0];
                REG_CHUNK:  chunk_reg  <= pwdata[CHUNK_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_STRIDE: prdata = {{(32-STRIDE_W){1'b0}}, stride_reg};
            REG_CHUNK:  prdata = {{(32-CHUNK_W){1'b0}}, chunk_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.slot_stride    = stride_reg;
    assign cfg.slots_in_chunk = chunk_reg;

endmodule

`default_nettype wire

// File: sv/fspa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module fspa_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [fspa_pkg::SLOT_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [fspa_pkg::SLOT_W-1:0] rd_data
);
    import fspa_pkg::*;

    logic [SLOT_W-1:0] mem [DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/fspa_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fspa_core #(
    parameter int MAX_SLOTS = 256,
    parameter int PTR_W     = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fspa_pkg::cfg_t                cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [fspa_pkg::SLOT_W-1:0]   s_slot_index,
    input  wire logic                          s_slot_present,
    input  wire logic                          s_shutdown,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [fspa_pkg::SLOT_W-1:0]        m_granted_slot,
    output logic [fspa_pkg::OFFS_W-1:0]        m_byte_offset,
    output logic [fspa_pkg::CNT_W-1:0]         m_slots_available,
    output logic                               m_none_in_use,
    output logic                               mem_wr_en,
    output logic [PTR_W-1:0]                   mem_wr_addr,
    output logic [fspa_pkg::SLOT_W-1:0]        mem_wr_data,
    output logic                               mem_rd_en,
    output logic [PTR_W-1:0]                   mem_rd_addr,
    input  wire logic [fspa_pkg::SLOT_W-1:0]   mem_rd_data
);
    import fspa_pkg::*;

    localparam int QC_W  = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W = ((QC_W > CNT_W) ? QC_W : CNT_W) + 1;
    localparam int CLAMP = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
    localparam int PROD_W = SLOT_W + STRIDE_W;

    fsm_t              state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [QC_W-1:0]   qcount_reg, qcount_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [CNT_W-1:0]  alloc_reg, alloc_next;
    logic              m_valid_reg, m_valid_next;

    // latched item and step results (payload)
    cmd_t              cmd_reg, cmd_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              present_reg, present_next;
    logic              shut_reg, shut_next;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              load_out;

    logic [1:0]        out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [OFFS_W-1:0] out_offset_reg;
    logic [CNT_W-1:0]  out_avail_reg;
    logic              out_none_reg;

    logic [CNT_W-1:0]  chunk_n;
    logic [CNT_W-1:0]  fresh_left;
    logic [SUM_W-1:0]  total;
    logic [CNT_W-1:0]  avail;
    logic [PROD_W-1:0] product;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(MAX_SLOTS - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign chunk_n    = (cfg.slots_in_chunk > CNT_W'(CLAMP)) ? CNT_W'(CLAMP)
                                                             : cfg.slots_in_chunk;
    assign fresh_left = (chunk_n > fresh_reg) ? chunk_n - fresh_reg : '0;
    assign total      = SUM_W'(qcount_reg) + SUM_W'(fresh_left);
    assign avail      = (total > SUM_W'(CNT_MAX)) ? CNT_MAX : total[CNT_W-1:0];
    assign product    = PROD_W'(slot_reg) * PROD_W'(cfg.slot_stride);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        qcount_next  = qcount_reg;
        fresh_next   = fresh_reg;
        alloc_next   = alloc_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        present_next = present_reg;
        shut_next    = shut_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg && !m_ready;
        load_out     = 1'b0;
        s_ready      = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = head_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = tail_reg;
        mem_wr_data  = idx_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next     = cmd_t'(s_cmd);
                    idx_next     = s_slot_index;
                    present_next = s_slot_present;
                    shut_next    = s_shutdown;
                    // queue head is fetched up front; data lands next cycle
                    mem_rd_en    = (cmd_t'(s_cmd) == CMD_ALLOC);
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                slot_next   = '0;
                state_next  = S_FINISH;
                if (cmd_reg == CMD_ALLOC) begin
                    status_next = ST_GRANT;
                    if (qcount_reg != '0) begin
                        slot_next   = mem_rd_data;
                        head_next   = wrap_next(head_reg);
                        qcount_next = qcount_reg - 1'b1;
                    end else if (fresh_reg < chunk_n) begin
                        slot_next  = fresh_reg[SLOT_W-1:0];
                        fresh_next = fresh_reg + 1'b1;
                    end else begin
                        status_next = ST_FULL;
                    end
                    if (status_next == ST_GRANT && alloc_reg != CNT_MAX) begin
                        alloc_next = alloc_reg + 1'b1;
                    end
                end else begin
                    status_next = ST_FREE;
                    if (present_reg) begin
                        if (alloc_reg != '0) begin
                            alloc_next = alloc_reg - 1'b1;
                        end
                        // full queue drops the slot like a shutdown free
                        if (!shut_reg && qcount_reg != QC_W'(MAX_SLOTS)) begin
                            mem_wr_en   = 1'b1;
                            tail_next   = wrap_next(tail_reg);
                            qcount_next = qcount_reg + 1'b1;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            qcount_reg  <= '0;
            fresh_reg   <= '0;
            alloc_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            qcount_reg  <= qcount_next;
            fresh_reg   <= fresh_next;
            alloc_reg   <= alloc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        present_reg <= present_next;
        shut_reg    <= shut_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        if (load_out) begin
            out_status_reg <= status_reg;
            out_slot_reg   <= slot_reg;
            out_offset_reg <= product[OFFS_W-1:0];
            out_avail_reg  <= avail;
            out_none_reg   <= (alloc_reg == '0);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_status_reg;
    assign m_granted_slot    = out_slot_reg;
    assign m_byte_offset     = out_offset_reg;
    assign m_slots_available = out_avail_reg;
    assign m_none_in_use     = out_none_reg;

    a_qcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg <= QC_W'(MAX_SLOTS))
        else $error("free queue count above capacity");

    a_ptr_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (qcount_reg == '0 || qcount_reg == QC_W'(MAX_SLOTS)) |-> head_reg == tail_reg)
        else $error("queue pointers disagree with count");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted item did not start execution");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FINISH && m_valid_reg && !m_ready |=> state_reg == S_FINISH)
        else $error("result overwrote an item not yet taken");

    a_no_mem_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
        else $error("queue read and write in the same cycle");

endmodule

`default_nettype wire

// File: sv/fixed_slot_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// s_*       in         s_valid/s_ready   cmd, slot_index, slot_present, shutdown
// m_*       out        m_valid/m_ready   status, granted_slot, byte_offset,
//                                        slots_available, none_in_use
// APB       in/out     psel/penable      0x0 slot_stride, 0x4 slots_in_chunk
//
// Each item steps through accept with free-queue read, update, then offset multiply.
// The free-queue RAM read is registered, and the multiply result is registered at the output.
// A new item is taken while the previous result waits in the output register.
// A stalled result holds the sequencer in its last step; nothing is dropped.
// Synchronous active-low reset; queue contents are not cleared.

module fixed_slot_pool_allocator #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [fspa_pkg::SLOT_W-1:0]   s_slot_index,
    input  wire logic                          s_slot_present,
    input  wire logic                          s_shutdown,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [fspa_pkg::SLOT_W-1:0]        m_granted_slot,
    output logic [fspa_pkg::OFFS_W-1:0]        m_byte_offset,
    output logic [fspa_pkg::CNT_W-1:0]         m_slots_available,
    output logic                               m_none_in_use
);
    import fspa_pkg::*;

    localparam int PTR_W = $clog2(MAX_SLOTS);

    cfg_t              cfg;
    logic              mem_wr_en;
    logic [PTR_W-1:0]  mem_wr_addr;
    logic [SLOT_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [PTR_W-1:0]  mem_rd_addr;
    logic [SLOT_W-1:0] mem_rd_data;

    fspa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fspa_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (PTR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fspa_core #(
        .MAX_SLOTS (MAX_SLOTS),
        .PTR_W     (PTR_W)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_slot_index      (s_slot_index),
        .s_slot_present    (s_slot_present),
        .s_shutdown        (s_shutdown),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_slot    (m_granted_slot),
        .m_byte_offset     (m_byte_offset),
        .m_slots_available (m_slots_available),
        .m_none_in_use     (m_none_in_use),
        .mem_wr_en         (mem_wr_en),
        .mem_wr_addr       (mem_wr_addr),
        .mem_wr_data       (mem_wr_data),
        .mem_rd_en         (mem_rd_en),
        .mem_rd_addr       (mem_rd_addr),
        .mem_rd_data       (mem_rd_data)
    );

endmodule

`default_nettype wire
